@@ hw/rtl/sha1he_pkg.sv @@
// Shared types and constants for the SHA-1 hash engine.
package sha1he_pkg;

   typedef logic [31:0] word_type;

   // One queued request after the front end has dropped empty ones.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } entry_type;

   localparam word_type InitH0 = 32'h67452301;
   localparam word_type InitH1 = 32'hEFCDAB89;
   localparam word_type InitH2 = 32'h98BADCFE;
   localparam word_type InitH3 = 32'h10325476;
   localparam word_type InitH4 = 32'hC3D2E1F0;

   localparam word_type RoundK0 = 32'h5A827999;
   localparam word_type RoundK1 = 32'h6ED9EBA1;
   localparam word_type RoundK2 = 32'h8F1BBCDC;
   localparam word_type RoundK3 = 32'hCA62C1D6;

   localparam logic [7:0] PadMark = 8'h80;

   localparam int         DigestWords = 5;
   localparam logic [2:0] LastWordIndex = 3'd4;

   // Request queue between the front and back ends.
   localparam int         QueueDepth = 4;
   localparam int         QueuePtrBits = 2;
   localparam logic [2:0] QueueFull = 3'd4;

endpackage

@@ hw/rtl/sha1he_if.sv @@
// Valid/ready channel interfaces for the request and digest sides.
interface sha1he_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       message_end;

   modport source (output valid, data_byte, byte_present, message_end, input ready);
   modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha1he_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hw/rtl/sha1he_front.sv @@
// Front end: accepts requests, drops empty ones, queues the rest.
module sha1he_front (
   input  logic                  clock,
   input  logic                  reset,
   sha1he_req_if.sink            req_chan,
   output sha1he_pkg::entry_type q_entry,
   output logic                  q_valid,
   input  logic                  q_ready
);

   sha1he_pkg::entry_type                 store_ff [sha1he_pkg::QueueDepth];
   logic [sha1he_pkg::QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sha1he_pkg::QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sha1he_pkg::QueuePtrBits:0]     count_ff, count_in;
   logic                                  accept;
   logic                                  push;
   logic                                  pop;

   assign req_chan.ready = (count_ff != sha1he_pkg::QueueFull);
   assign accept = req_chan.valid && req_chan.ready;
   // a request with no byte and no end has no effect: never queued
   assign push = accept && (req_chan.byte_present || req_chan.message_end);
   assign q_valid = (count_ff != '0);
   assign pop = q_valid && q_ready;
   assign q_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= '{data_byte:    req_chan.data_byte,
                                  byte_present: req_chan.byte_present,
                                  message_end:  req_chan.message_end};
      end
   end

endmodule

@@ hw/rtl/sha1he_core.sv @@
// Back end: block absorb, padding, 80-round compression and digest output.
module sha1he_core (
   input  logic                  clock,
   input  logic                  reset,
   input  sha1he_pkg::entry_type q_entry,
   input  logic                  q_valid,
   output logic                  q_ready,
   sha1he_rsp_if.source          rsp_chan
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PAD    = 3'd1;
   localparam logic [2:0] S_ROUND  = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   localparam logic [6:0] LastRound = 7'd79;
   localparam logic [5:0] LastFill  = 6'd63;
   localparam logic [5:0] LenFill   = 6'd56;

   logic [2:0]                state_ff, state_in;
   logic [5:0]                fill_ff, fill_in;
   logic [63:0]               bits_ff, bits_in;
   sha1he_pkg::word_type      chain_ff [sha1he_pkg::DigestWords];
   sha1he_pkg::word_type      chain_in [sha1he_pkg::DigestWords];
   logic                      pad_ff, pad_in;
   logic                      mark_ff, mark_in;
   logic [3:0]                len_cnt_ff, len_cnt_in;
   logic [2:0]                word_cnt_ff, word_cnt_in;
   logic [6:0]                round_ff, round_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload registers
   sha1he_pkg::word_type      win_ff [16];
   sha1he_pkg::word_type      win_in [16];
   sha1he_pkg::word_type      a_ff, b_ff, c_ff, d_ff, e_ff;
   sha1he_pkg::word_type      a_in, b_in, c_in, d_in, e_in;
   sha1he_pkg::word_type      rsp_word_ff, rsp_word_in;
   logic [2:0]                rsp_index_ff, rsp_index_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      push_en;
   logic [7:0]                push_val;
   logic                      to_compress;
   logic                      len_phase;
   logic [63:0]               len_shift;
   logic                      out_load;
   sha1he_pkg::word_type      f_val;
   sha1he_pkg::word_type      k_val;
   sha1he_pkg::word_type      t_val;
   sha1he_pkg::word_type      sched_x;

   assign q_ready = (state_ff == S_IDLE);
   assign out_load = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.digest_word = rsp_word_ff;
   assign rsp_chan.word_index = rsp_index_ff;
   assign rsp_chan.last_word = rsp_last_ff;

   // length bytes go out most significant first
   assign len_shift = bits_ff >> {~len_cnt_ff[2:0], 3'b000};
   assign len_phase = mark_ff && !((len_cnt_ff == 4'd0) && (fill_ff != LenFill));

   always_comb begin
      push_en = 1'b0;
      push_val = q_entry.data_byte;
      priority if (state_ff == S_IDLE) begin
         push_en = q_valid && q_entry.byte_present;
      end else if (state_ff == S_PAD) begin
         push_en = 1'b1;
         priority if (!mark_ff) begin
            push_val = sha1he_pkg::PadMark;
         end else if (len_phase) begin
            push_val = len_shift[7:0];
         end else begin
            push_val = 8'h00;
         end
      end else begin
         push_en = 1'b0;
      end
   end

   assign to_compress = push_en && (fill_ff == LastFill);

   // round function
   always_comb begin
      priority if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1he_pkg::RoundK0;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1he_pkg::RoundK1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1he_pkg::RoundK2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1he_pkg::RoundK3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + win_ff[0];
   // window holds w[t..t+15]; this makes w[t+16]
   assign sched_x = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      chain_in = chain_ff;
      pad_in = pad_ff;
      mark_in = mark_ff;
      len_cnt_in = len_cnt_ff;
      word_cnt_in = word_cnt_ff;
      round_in = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      win_in = win_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      rsp_word_in = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in = rsp_last_ff;

      if (push_en) begin
         for (int k = 0; k < 15; k++) begin
            win_in[k] = {win_ff[k][23:0], win_ff[k+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], push_val};
         fill_in = fill_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_entry.byte_present) begin
                  bits_in = bits_ff + 64'd8;
               end
               priority if (to_compress) begin
                  state_in = S_ROUND;
                  pad_in = q_entry.message_end;
               end else if (q_entry.message_end) begin
                  state_in = S_PAD;
                  pad_in = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAD: begin
            priority if (!mark_ff) begin
               mark_in = 1'b1;
            end else if (len_phase) begin
               len_cnt_in = len_cnt_ff + 1'b1;
            end else begin
               mark_in = 1'b1;
            end
            if (to_compress) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            for (int k = 0; k < 15; k++) begin
               win_in[k] = win_ff[k+1];
            end
            win_in[15] = {sched_x[30:0], sched_x[31]};
            a_in = t_val;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            round_in = round_ff + 1'b1;
            if (round_ff == LastRound) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            priority if (!pad_ff) begin
               state_in = S_IDLE;
            end else if (len_cnt_ff[3]) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_word_in = chain_ff[word_cnt_ff];
               rsp_index_in = word_cnt_ff;
               rsp_last_in = (word_cnt_ff == sha1he_pkg::LastWordIndex);
               word_cnt_in = word_cnt_ff + 1'b1;
               if (word_cnt_ff == sha1he_pkg::LastWordIndex) begin
                  chain_in[0] = sha1he_pkg::InitH0;
                  chain_in[1] = sha1he_pkg::InitH1;
                  chain_in[2] = sha1he_pkg::InitH2;
                  chain_in[3] = sha1he_pkg::InitH3;
                  chain_in[4] = sha1he_pkg::InitH4;
                  bits_in = '0;
                  pad_in = 1'b0;
                  mark_in = 1'b0;
                  len_cnt_in = '0;
                  word_cnt_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (to_compress) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
         round_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         bits_ff <= '0;
         chain_ff[0] <= sha1he_pkg::InitH0;
         chain_ff[1] <= sha1he_pkg::InitH1;
         chain_ff[2] <= sha1he_pkg::InitH2;
         chain_ff[3] <= sha1he_pkg::InitH3;
         chain_ff[4] <= sha1he_pkg::InitH4;
         pad_ff <= 1'b0;
         mark_ff <= 1'b0;
         len_cnt_ff <= '0;
         word_cnt_ff <= '0;
         round_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         chain_ff <= chain_in;
         pad_ff <= pad_in;
         mark_ff <= mark_in;
         len_cnt_ff <= len_cnt_in;
         word_cnt_ff <= word_cnt_in;
         round_ff <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      rsp_word_ff <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

@@ hw/rtl/sha1_hash_engine_unit.sv @@
// SHA-1 hash engine top level: request queue front end and hashing back end.
//
// Feeds a message one byte per request and returns its SHA-1 digest as five
// 32-bit words, most significant byte first, word_index 0 to 4, last_word on
// the fifth. A request with message_end closes the message (its byte, if
// present, is part of it); a request with neither byte nor end is dropped.
// The front end queues up to four requests. The back end absorbs one byte a
// cycle while idle; each full 64-byte block then runs one compression round
// per cycle, 80 rounds followed by the chaining add, and no bytes are taken
// while a block is compressed. Closing a message adds up to 64 padding bytes
// per block still to fill, one or two compressions, and the output of the
// five digest words; then the engine is reset to the initial chaining value
// for the next message.
module sha1_hash_engine_unit (
   input logic           clock,
   input logic           reset,
   sha1he_req_if.sink    req_chan,
   sha1he_rsp_if.source  rsp_chan
);

   sha1he_pkg::entry_type q_entry;
   logic                  q_valid;
   logic                  q_ready;

   sha1he_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_entry  (q_entry),
      .q_valid  (q_valid),
      .q_ready  (q_ready)
   );

   sha1he_core u_core (
      .clock    (clock),
      .reset    (reset),
      .q_entry  (q_entry),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .rsp_chan (rsp_chan)
   );

endmodule
